// ===== hdl/inverse_park_svpwm_modulator_defines.svh =====
// Assertion macros shared by the checker files of the modulator.
`ifndef INVERSE_PARK_SVPWM_MODULATOR_DEFINES_SVH
`define INVERSE_PARK_SVPWM_MODULATOR_DEFINES_SVH

// Consequent must hold in the cycle after the antecedent, outside reset.
`define IPS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("modulator check failed");

// Consequent must hold in the same cycle as the antecedent, outside reset.
`define IPS_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("modulator check failed");

// Consequent must hold in the next cycle, checked during reset as well.
`define IPS_ASSERT_NEXT_ALWAYS(lbl, clk, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("modulator check failed");

`endif

// ===== hdl/ips_pkg.sv =====
// Shared constants and types of the inverse Park / SVPWM modulator.
`default_nettype none

package ips_pkg;

  // Odd series of sin(pi/2*z), Q30 coefficients
  localparam logic [30:0] SIN_C1 = 31'd1686629713;
  localparam logic [30:0] SIN_C3 = 31'd693598669;
  localparam logic [30:0] SIN_C5 = 31'd85569306;
  localparam logic [30:0] SIN_C7 = 31'd5026994;
  localparam logic [30:0] SIN_C9 = 31'd172273;
  localparam logic [30:0] Q30_ONE = 31'd1073741824;
  localparam longint unsigned SQRT3_Q30 = 64'd1859775393;

  localparam int HORNER_STEPS = 4;
  localparam logic [30:0] HORNER_COEF [HORNER_STEPS] = '{SIN_C7, SIN_C5, SIN_C3, SIN_C1};

  // One sine evaluation lane: running Horner value, folded argument, its square
  typedef struct packed {
    logic [30:0] p;
    logic [30:0] z;
    logic [30:0] z2;
    logic        neg;
  } ips_lane_t;

  typedef struct packed {
    logic signed [15:0] d;
    logic signed [15:0] q;
    ips_lane_t          sn;
    ips_lane_t          cs;
  } ips_cell_t;

  typedef struct packed {
    logic [15:0] a;
    logic [15:0] b;
    logic [15:0] c;
  } ips_duty_t;

endpackage

`default_nettype wire

// ===== hdl/ips_if.sv =====
// Valid/ready channel interfaces for the command input and duty output.
`default_nettype none

interface ips_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] d_voltage;
  logic signed [15:0] q_voltage;
  logic [15:0]        rotor_angle;

  modport source (output valid, output d_voltage, output q_voltage, output rotor_angle,
                  input ready);
  modport sink (input valid, input d_voltage, input q_voltage, input rotor_angle,
                output ready);
endinterface

interface ips_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] duty_phase_a;
  logic [15:0] duty_phase_b;
  logic [15:0] duty_phase_c;

  modport source (output valid, output duty_phase_a, output duty_phase_b,
                  output duty_phase_c, input ready);
  modport sink (input valid, input duty_phase_a, input duty_phase_b, input duty_phase_c,
                output ready);
endinterface

`default_nettype wire

// ===== hdl/ips_phase.sv =====
// Angle quantization, phase scaling and quadrant folding ahead of the sine cells.
`default_nettype none

module ips_phase #(
  parameter int unsigned SINE_TABLE_ENTRIES = 1024
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic               vld_i,
  input  logic signed [15:0] d_i,
  input  logic signed [15:0] q_i,
  input  logic [15:0]        ang_i,
  output logic               vld_o,
  output ips_pkg::ips_cell_t cell_o
);
  import ips_pkg::*;

  // phase = idx * 2^32 / E = idx*RECIP + floor(idx*REM0 / E)
  localparam longint unsigned TWO32 = 64'h1_0000_0000;
  localparam longint unsigned RECIP = TWO32 / SINE_TABLE_ENTRIES;
  localparam longint unsigned REM0  = TWO32 - RECIP * SINE_TABLE_ENTRIES;
  localparam longint unsigned FRAC  = (REM0 << 16) / SINE_TABLE_ENTRIES;
  localparam logic [31:0] ENT       = 32'(SINE_TABLE_ENTRIES);

  logic [5:0] vld_r;

  logic signed [15:0] d1_r, q1_r, d2_r, q2_r, d3_r, q3_r, d4_r, q4_r, d5_r, q5_r;
  logic [15:0] idx1_r;
  logic [31:0] base2_r, rem2_r;
  logic [15:0] est2_r;
  logic [31:0] base3_r, rem3_r, back3_r;
  logic [15:0] est3_r;
  logic [31:0] ph4_r;
  ips_lane_t   sn5_r, cs5_r;
  ips_cell_t   cell6_r;

  logic [15:0] idx_nxt;
  logic [31:0] diff_nxt;
  logic [31:0] ph_nxt;
  ips_cell_t   cell_nxt;

  function automatic ips_lane_t fold_quadrant(input logic [31:0] ph);
    ips_lane_t   lane;
    logic [30:0] r;
    r         = {1'b0, ph[29:0]};
    lane      = '0;
    lane.z    = ph[30] ? Q30_ONE - r : r;
    lane.neg  = ph[31];
    return lane;
  endfunction

  assign idx_nxt  = 16'((32'(ang_i) * ENT) >> 16);
  assign diff_nxt = rem3_r - back3_r;
  assign ph_nxt   = base3_r + 32'(est3_r) + 32'(diff_nxt >= ENT);

  always_comb begin
    cell_nxt       = '0;
    cell_nxt.d     = d5_r;
    cell_nxt.q     = q5_r;
    cell_nxt.sn    = sn5_r;
    cell_nxt.cs    = cs5_r;
    cell_nxt.sn.p  = SIN_C9;
    cell_nxt.cs.p  = SIN_C9;
    cell_nxt.sn.z2 = 31'((62'(sn5_r.z) * 62'(sn5_r.z)) >> 30);
    cell_nxt.cs.z2 = 31'((62'(cs5_r.z) * 62'(cs5_r.z)) >> 30);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[4:0], vld_i};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d1_r    <= d_i;
      q1_r    <= q_i;
      idx1_r  <= idx_nxt;
      d2_r    <= d1_r;
      q2_r    <= q1_r;
      base2_r <= 32'(idx1_r) * 32'(RECIP);
      rem2_r  <= 32'(idx1_r) * 32'(REM0);
      est2_r  <= 16'((32'(idx1_r) * 32'(FRAC)) >> 16);
      d3_r    <= d2_r;
      q3_r    <= q2_r;
      base3_r <= base2_r;
      rem3_r  <= rem2_r;
      est3_r  <= est2_r;
      back3_r <= 32'(est2_r) * ENT;
      d4_r    <= d3_r;
      q4_r    <= q3_r;
      ph4_r   <= ph_nxt;
      d5_r    <= d4_r;
      q5_r    <= q4_r;
      sn5_r   <= fold_quadrant(ph4_r);
      cs5_r   <= fold_quadrant(ph4_r + 32'(Q30_ONE));
      cell6_r <= cell_nxt;
    end
  end

  assign vld_o  = vld_r[5];
  assign cell_o = cell6_r;

endmodule

`default_nettype wire

// ===== hdl/ips_horner_cell.sv =====
// One Horner step of the sine series, for the sine and cosine lanes together.
`default_nettype none

module ips_horner_cell (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic               vld_i,
  input  logic [30:0]        coef,
  input  ips_pkg::ips_cell_t cell_i,
  output logic               vld_o,
  output ips_pkg::ips_cell_t cell_o
);
  import ips_pkg::*;

  logic      vld_r;
  ips_cell_t cell_r;
  ips_cell_t cell_nxt;
  logic [61:0] prod_sn, prod_cs;

  assign prod_sn = 62'(cell_i.sn.p) * 62'(cell_i.sn.z2);
  assign prod_cs = 62'(cell_i.cs.p) * 62'(cell_i.cs.z2);

  always_comb begin
    cell_nxt      = cell_i;
    cell_nxt.sn.p = coef - 31'(prod_sn >> 30);
    cell_nxt.cs.p = coef - 31'(prod_cs >> 30);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cell_r <= cell_nxt;
    end
  end

  assign vld_o  = vld_r;
  assign cell_o = cell_r;

endmodule

`default_nettype wire

// ===== hdl/ips_mod.sv =====
// Sine finish, inverse Park, inverse Clarke and min-max offset duty pipeline.
`default_nettype none

module ips_mod #(
  parameter int unsigned FRACTION_BITS = 15
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic               vld_i,
  input  ips_pkg::ips_cell_t cell_i,
  output logic               vld_o,
  output ips_pkg::ips_duty_t duty_o
);
  import ips_pkg::*;

  localparam int F  = FRACTION_BITS;
  localparam int SW = F + 2;
  localparam int PW = F + 18;
  localparam int AW = F + 4;
  localparam int KW = F + 2;
  localparam int MW = KW + AW;
  localparam int TW = F + 4;
  localparam int VW = F + 6;
  localparam int NW = VW + 3;
  localparam int DW = NW + 16;
  localparam longint unsigned KV =
    (SQRT3_Q30 + ((64'd1 << (30 - F)) >> 1)) >> (30 - F);
  localparam logic signed [KW-1:0] KS    = KW'(KV);
  localparam logic [F+1:0]         ONE_F = (F + 2)'(1) << F;

  logic [6:0] vld_r;

  // stage 1: series times z
  logic signed [15:0] d1_r, q1_r;
  logic [30:0] sraw_sn1_r, sraw_cs1_r;
  logic        neg_sn1_r, neg_cs1_r;
  // stage 2: rounded sine and cosine
  logic signed [15:0]   d2_r, q2_r;
  logic signed [SW-1:0] sin2_r, cos2_r;
  // stage 3: rotation products
  logic signed [PW-1:0] dc3_r, qs3_r, ds3_r, qc3_r;
  // stage 4: alpha and beta
  logic signed [AW-1:0] alpha4_r, beta4_r;
  // stage 5: scaled beta
  logic signed [AW-1:0] alpha5_r;
  logic signed [TW-1:0] t5_r;
  // stage 6: phase voltages and offset sum
  logic signed [VW-1:0] va6_r, vb6_r, vc6_r;
  logic signed [VW:0]   ext6_r;
  // stage 7: duties
  ips_duty_t duty7_r;

  logic signed [AW-1:0] alpha_nxt, beta_nxt;
  logic signed [TW-1:0] t_nxt;
  logic signed [VW-1:0] va_nxt, vb_nxt, vc_nxt, mx_nxt, mn_nxt;

  function automatic logic signed [SW-1:0] round_sine(input logic [30:0] sraw,
                                                      input logic neg);
    logic [F+31:0] acc;
    logic [F+1:0]  mag;
    acc = ((F + 32)'(sraw) << F) + ((F + 32)'(1) << 29);
    mag = (F + 2)'(acc >> 30);
    if (mag > ONE_F) begin
      mag = ONE_F;
    end
    return neg ? -$signed(mag) : $signed(mag);
  endfunction

  function automatic logic [15:0] to_duty(input logic signed [VW-1:0] x,
                                          input logic signed [VW:0] ext);
    logic signed [NW-1:0] num;
    logic signed [DW-1:0] scaled;
    num    = NW'(x) + NW'(x) - NW'(ext) + NW'(longint'(4) << F);
    scaled = ((DW'(num) <<< 16) + DW'(longint'(1) << (F + 2))) >>> (F + 3);
    if (scaled < 0) begin
      return 16'd0;
    end else if (scaled > DW'(65535)) begin
      return 16'hFFFF;
    end
    return 16'(scaled);
  endfunction

  assign alpha_nxt = AW'((PW'(dc3_r) - PW'(qs3_r) + PW'(16384)) >>> 15);
  assign beta_nxt  = AW'((PW'(ds3_r) + PW'(qc3_r) + PW'(16384)) >>> 15);
  assign t_nxt     = TW'((MW'(KS) * MW'(beta4_r) + MW'(longint'(1) << (F - 1))) >>> F);

  assign va_nxt = VW'(alpha5_r) + VW'(alpha5_r);
  assign vb_nxt = VW'(t5_r) - VW'(alpha5_r);
  assign vc_nxt = -VW'(alpha5_r) - VW'(t5_r);

  always_comb begin
    mx_nxt = va_nxt;
    mn_nxt = va_nxt;
    if (vb_nxt > mx_nxt) mx_nxt = vb_nxt;
    if (vc_nxt > mx_nxt) mx_nxt = vc_nxt;
    if (vb_nxt < mn_nxt) mn_nxt = vb_nxt;
    if (vc_nxt < mn_nxt) mn_nxt = vc_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[5:0], vld_i};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d1_r       <= cell_i.d;
      q1_r       <= cell_i.q;
      sraw_sn1_r <= 31'((62'(cell_i.sn.p) * 62'(cell_i.sn.z)) >> 30);
      sraw_cs1_r <= 31'((62'(cell_i.cs.p) * 62'(cell_i.cs.z)) >> 30);
      neg_sn1_r  <= cell_i.sn.neg;
      neg_cs1_r  <= cell_i.cs.neg;
      d2_r       <= d1_r;
      q2_r       <= q1_r;
      sin2_r     <= round_sine(sraw_sn1_r, neg_sn1_r);
      cos2_r     <= round_sine(sraw_cs1_r, neg_cs1_r);
      dc3_r      <= PW'(d2_r) * PW'(cos2_r);
      qs3_r      <= PW'(q2_r) * PW'(sin2_r);
      ds3_r      <= PW'(d2_r) * PW'(sin2_r);
      qc3_r      <= PW'(q2_r) * PW'(cos2_r);
      alpha4_r   <= alpha_nxt;
      beta4_r    <= beta_nxt;
      alpha5_r   <= alpha4_r;
      t5_r       <= t_nxt;
      va6_r      <= va_nxt;
      vb6_r      <= vb_nxt;
      vc6_r      <= vc_nxt;
      ext6_r     <= (VW + 1)'(mx_nxt) + (VW + 1)'(mn_nxt);
      duty7_r.a  <= to_duty(va6_r, ext6_r);
      duty7_r.b  <= to_duty(vb6_r, ext6_r);
      duty7_r.c  <= to_duty(vc6_r, ext6_r);
    end
  end

  assign vld_o  = vld_r[6];
  assign duty_o = duty7_r;

endmodule

`default_nettype wire

// ===== hdl/inverse_park_svpwm_modulator.sv =====
// Top level: inverse Park plus min-max zero-sequence SVPWM duty generator.
// Structure: 6 phase stages, 4 sine cells, 7 modulator stages and 1 output register
// between input accept and out valid. Throughput: one item per cycle while the skid stage is empty.
// The whole pipeline advances together; a two-entry output register and skid stage
// keep the input open while one finished item waits downstream.
// Reset (synchronous, active low) empties every stage; in_ch.ready is high after it.
`default_nettype none

module inverse_park_svpwm_modulator #(
  parameter int unsigned SINE_TABLE_ENTRIES = 1024,
  parameter int unsigned FRACTION_BITS      = 15
) (
  input logic      clk,
  input logic      rst_n,
  ips_in_if.sink   in_ch,
  ips_out_if.source out_ch
);
  import ips_pkg::*;

  logic      en;
  logic      take;
  logic      ph_vld;
  ips_cell_t ph_cell;
  logic      cell_vld [HORNER_STEPS+1];
  ips_cell_t cell_dat [HORNER_STEPS+1];
  logic      tail_vld;
  ips_duty_t tail_duty;

  logic      out_v_r, skid_v_r;
  logic      out_v_nxt, skid_v_nxt;
  ips_duty_t out_r, skid_r;

  assign en          = !skid_v_r;
  assign take        = !out_v_r || out_ch.ready;
  assign in_ch.ready = en;

  ips_phase #(
    .SINE_TABLE_ENTRIES(SINE_TABLE_ENTRIES)
  ) u_phase (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .vld_i  (in_ch.valid),
    .d_i    (in_ch.d_voltage),
    .q_i    (in_ch.q_voltage),
    .ang_i  (in_ch.rotor_angle),
    .vld_o  (ph_vld),
    .cell_o (ph_cell)
  );

  assign cell_vld[0] = ph_vld;
  assign cell_dat[0] = ph_cell;

  for (genvar i = 0; i < HORNER_STEPS; i++) begin : g_cell
    ips_horner_cell u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .en     (en),
      .vld_i  (cell_vld[i]),
      .coef   (HORNER_COEF[i]),
      .cell_i (cell_dat[i]),
      .vld_o  (cell_vld[i+1]),
      .cell_o (cell_dat[i+1])
    );
  end

  ips_mod #(
    .FRACTION_BITS(FRACTION_BITS)
  ) u_mod (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .vld_i  (cell_vld[HORNER_STEPS]),
    .cell_i (cell_dat[HORNER_STEPS]),
    .vld_o  (tail_vld),
    .duty_o (tail_duty)
  );

  always_comb begin
    out_v_nxt  = out_v_r;
    skid_v_nxt = skid_v_r;
    if (take) begin
      // drain the skid first, else take the pipeline tail
      out_v_nxt  = skid_v_r ? 1'b1 : tail_vld;
      skid_v_nxt = 1'b0;
    end else if (tail_vld && en) begin
      skid_v_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      out_v_r  <= out_v_nxt;
      skid_v_r <= skid_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_r <= skid_v_r ? skid_r : tail_duty;
    end
    if (!take && tail_vld && en) begin
      skid_r <= tail_duty;
    end
  end

  assign out_ch.valid        = out_v_r;
  assign out_ch.duty_phase_a = out_r.a;
  assign out_ch.duty_phase_b = out_r.b;
  assign out_ch.duty_phase_c = out_r.c;

endmodule

`default_nettype wire

// ===== hdl/ips_checker.sv =====
// Port-level checks of the modulator, bound to the top level.
`default_nettype none
`include "inverse_park_svpwm_modulator_defines.svh"

module ips_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] duty_a,
  input logic [15:0] duty_b,
  input logic [15:0] duty_c
);

  logic [47:0] duties;

  assign duties = {duty_a, duty_b, duty_c};

  // a stalled item keeps its duties
  `IPS_ASSERT_NEXT(a_stall_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(duties))
  // input may only close while an item waits at the output
  `IPS_ASSERT_SAME(a_ready_when_empty, clk, rst_n, !out_valid, in_ready)
  // a delivered item always frees the skid stage
  `IPS_ASSERT_NEXT(a_ready_after_take, clk, rst_n, out_valid && out_ready, in_ready)
  // reset empties the output and opens the input
  `IPS_ASSERT_NEXT_ALWAYS(a_reset_empty, clk, !rst_n, !out_valid && in_ready)

endmodule

bind inverse_park_svpwm_modulator ips_checker u_ips_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .duty_a    (out_ch.duty_phase_a),
  .duty_b    (out_ch.duty_phase_b),
  .duty_c    (out_ch.duty_phase_c)
);

`default_nettype wire
